// ===== src/afs_pkg.sv =====
// Package for the animation frame selector: word types, field widths,
// mode and register index codes, and the shared remainder unit's control word.
// No dependencies.
package afs_pkg;

	localparam int TIME_W      = 48;
	localparam int DUR_W       = 32;
	localparam int FRAME_W     = 6;
	localparam int SIDX_W      = 6;
	localparam int CNT_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 48;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 2'd2;

	typedef struct packed {
		logic               mode;
		logic [SIDX_W-1:0]  step_index;
		logic [DUR_W-1:0]   step_duration_ms;
		logic [FRAME_W-1:0] step_frame;
		logic [TIME_W-1:0]  now_ms;
	} in_word_t;

	typedef struct packed {
		logic               frame_valid;
		logic [FRAME_W-1:0] frame_number;
	} out_word_t;

	typedef enum logic [1:0] {
		REM_HOLD,
		REM_CLEAR,
		REM_MOD,
		REM_WALK
	} rem_op_t;

	typedef struct packed {
		rem_op_t op;
		logic    dividend_bit;
	} rem_ctrl_t;

endpackage

// ===== src/afs_rem_unit.sv =====
// Shared conditional-subtract unit that holds the running remainder.
// Serves both the restoring modulo steps and the step-table walk.
// Depends on afs_pkg.
module afs_rem_unit import afs_pkg::*; #(
	parameter int TOT_W = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rem_ctrl_t        ctrl,
	input  logic [TOT_W-1:0] total,
	input  logic [DUR_W-1:0] dur,
	output logic             ge
);

	logic [TOT_W-1:0] rem_q;
	logic [TOT_W:0]   op_a;
	logic [TOT_W:0]   op_b;
	logic [TOT_W:0]   diff;

	// A modulo step shifts in the next dividend bit and compares against the
	// total; a walk step compares the remainder against one step duration.
	always_comb begin
		if (ctrl.op == REM_MOD) begin
			op_a = {rem_q, ctrl.dividend_bit};
			op_b = {1'b0, total};
		end else begin
			op_a = {1'b0, rem_q};
			op_b = {{(TOT_W + 1 - DUR_W){1'b0}}, dur};
		end
		diff = op_a - op_b;
		ge   = (op_a >= op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else begin
			case (ctrl.op)
				REM_CLEAR: rem_q <= '0;
				REM_MOD,
				REM_WALK:  rem_q <= ge ? diff[TOT_W-1:0] : op_a[TOT_W-1:0];
				default:   rem_q <= rem_q;
			endcase
		end
	end

endmodule

// ===== src/afs_step_table.sv =====
// Step table memory: one duration and one frame number per entry.
// One write port and one read port with registered read data. Depends on afs_pkg.
module afs_step_table import afs_pkg::*; #(
	parameter int MAX_STEPS = 64,
	parameter int IDX_W     = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [DUR_W-1:0]   wr_dur,
	input  logic [FRAME_W-1:0] wr_frame,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [DUR_W-1:0]   rd_dur,
	output logic [FRAME_W-1:0] rd_frame
);

	logic [DUR_W-1:0]   dur_mem   [MAX_STEPS];
	logic [FRAME_W-1:0] frame_mem [MAX_STEPS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dur_mem[wr_addr]   <= wr_dur;
			frame_mem[wr_addr] <= wr_frame;
		end
		rd_dur   <= dur_mem[rd_addr];
		rd_frame <= frame_mem[rd_addr];
	end

endmodule

// ===== src/animation_frame_selector.sv =====
// Top level of the animation frame selector: configuration registers, sequencer,
// running total and output register. Instantiates afs_step_table and afs_rem_unit;
// depends on afs_pkg.
//
//   Channel | Direction | Handshake              | Word
//   --------+-----------+------------------------+-----------------------------
//   in      | into      | in_valid / in_stall    | in_word_t  (write or query)
//   out     | out of    | out_valid / out_stall  | out_word_t (one per query)
//   cfg     | into      | cfg_we, no back-press. | cfg_index, cfg_data
//
// After reset the block clears the step table, one entry a cycle, holding in_stall
// high; configuration writes are taken meanwhile. A write word reads the old
// duration, subtracts it from the running total, adds the new one and writes the
// entry. A query runs the modulo loop (one dividend bit per cycle through the
// shared subtractor), then walks the steps through S_WALK_WAIT and S_WALK_CMP for
// the table's registered read. A query with no frames or no steps goes straight to
// S_FIN, and one before the start time or with a zero total skips the modulo loop.
// The block takes one word at a time; a finished result waits in the output
// register, so a stalled output holds only a block that has a new result.
module animation_frame_selector import afs_pkg::*; #(
	parameter int MAX_STEPS  = 64,
	parameter int MAX_FRAMES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	// The total of all durations needs room for MAX_STEPS full 32-bit values.
	localparam int TOT_W     = DUR_W + $clog2(MAX_STEPS);
	localparam int MOD_CNT_W = $clog2(TIME_W + 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_WALK_WAIT,
		S_WALK_CMP,
		S_FIN,
		S_WR_RD,
		S_WR_SUB,
		S_WR_ADD
	} state_t;

	state_t                 state_q;
	logic [TIME_W-1:0]      start_q;
	logic [CNT_W-1:0]       frame_count_q;
	logic [CNT_W-1:0]       step_count_q;
	logic [TOT_W-1:0]       total_q;
	logic [TIME_W-1:0]      diff_q;
	logic [MOD_CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]       step_q;
	logic [IDX_W-1:0]       idx_q;
	logic [DUR_W-1:0]       dur_q;
	logic [FRAME_W-1:0]     frame_q;
	out_word_t              res_q;
	logic                   out_valid_q;
	out_word_t              out_word_q;

	logic [CNT_W-1:0]       nframes;
	logic [CNT_W-1:0]       nsteps;
	logic                   more_steps;
	logic                   idx_in_range;
	logic [31:0]            idx_ext;

	logic                   tbl_we;
	logic [IDX_W-1:0]       tbl_waddr;
	logic [DUR_W-1:0]       tbl_wdur;
	logic [FRAME_W-1:0]     tbl_wframe;
	logic [IDX_W-1:0]       tbl_raddr;
	logic [DUR_W-1:0]       tbl_rdur;
	logic [FRAME_W-1:0]     tbl_rframe;

	rem_ctrl_t              rem_ctrl;
	logic                   rem_ge;

	// Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q       <= '0;
			frame_count_q <= '0;
			step_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MS:    start_q       <= cfg_data[TIME_W-1:0];
				CFG_FRAME_COUNT: frame_count_q <= cfg_data[CNT_W-1:0];
				CFG_STEP_COUNT:  step_count_q  <= cfg_data[CNT_W-1:0];
				default:         start_q       <= start_q;
			endcase
		end
	end

	// Counts above the table or frame limits act as the limits.
	assign nframes = (32'(frame_count_q) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : frame_count_q;
	assign nsteps  = (32'(step_count_q) > MAX_STEPS) ? CNT_W'(MAX_STEPS) : step_count_q;

	// The walk may go on only while a later step is in use.
	assign more_steps = (32'(step_q) + 32'd1) < 32'(nsteps);

	assign idx_ext      = 32'(in_word.step_index);
	assign idx_in_range = idx_ext < MAX_STEPS;

	// Table port selection. The clearing pass after reset reuses the step counter.
	always_comb begin
		tbl_we     = (state_q == S_CLEAR) || (state_q == S_WR_ADD);
		tbl_waddr  = (state_q == S_CLEAR) ? step_q : idx_q;
		tbl_wdur   = (state_q == S_CLEAR) ? '0 : dur_q;
		tbl_wframe = (state_q == S_CLEAR) ? '0 : frame_q;
		tbl_raddr  = (state_q == S_WR_RD) ? idx_q : step_q;
	end

	// Shared unit control: clear on a query, one modulo bit per cycle, then one
	// conditional subtract per step of the walk.
	always_comb begin
		rem_ctrl.op           = REM_HOLD;
		rem_ctrl.dividend_bit = diff_q[TIME_W-1];
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_word.mode == MODE_QUERY) begin
					rem_ctrl.op = REM_CLEAR;
				end
			end
			S_MOD: begin
				rem_ctrl.op = REM_MOD;
			end
			S_WALK_CMP: begin
				if (more_steps) begin
					rem_ctrl.op = REM_WALK;
				end
			end
			default: begin
				rem_ctrl.op = REM_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			total_q     <= '0;
			diff_q      <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			idx_q       <= '0;
			dur_q       <= '0;
			frame_q     <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			// The output register loads from the final state and empties when taken.
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (32'(step_q) == MAX_STEPS - 1) begin
						step_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_word.mode == MODE_QUERY) begin
							step_q <= '0;
							if (nframes == '0 || nsteps == '0) begin
								res_q   <= '0;
								state_q <= S_FIN;
							end else if (in_word.now_ms < start_q || total_q == '0) begin
								// The remainder stays zero, so the walk starts at step 0.
								state_q <= S_WALK_WAIT;
							end else begin
								diff_q  <= in_word.now_ms - start_q;
								cnt_q   <= MOD_CNT_W'(TIME_W);
								state_q <= S_MOD;
							end
						end else if (idx_in_range) begin
							idx_q   <= idx_ext[IDX_W-1:0];
							dur_q   <= (in_word.step_duration_ms == '0) ? DUR_W'(1)
							           : in_word.step_duration_ms;
							frame_q <= in_word.step_frame;
							state_q <= S_WR_RD;
						end
					end
				end
				S_MOD: begin
					diff_q <= {diff_q[TIME_W-2:0], 1'b0};
					cnt_q  <= cnt_q - MOD_CNT_W'(1);
					if (cnt_q == MOD_CNT_W'(1)) begin
						state_q <= S_WALK_WAIT;
					end
				end
				S_WALK_WAIT: begin
					state_q <= S_WALK_CMP;
				end
				S_WALK_CMP: begin
					if (more_steps && rem_ge) begin
						step_q  <= step_q + IDX_W'(1);
						state_q <= S_WALK_WAIT;
					end else begin
						res_q.frame_valid  <= {1'b0, tbl_rframe} < nframes;
						res_q.frame_number <= tbl_rframe;
						state_q            <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_word_q <= res_q;
						state_q    <= S_IDLE;
					end
				end
				S_WR_RD: begin
					state_q <= S_WR_SUB;
				end
				S_WR_SUB: begin
					total_q <= total_q - TOT_W'(tbl_rdur);
					state_q <= S_WR_ADD;
				end
				S_WR_ADD: begin
					total_q <= total_q + TOT_W'(dur_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	afs_step_table #(
		.MAX_STEPS (MAX_STEPS),
		.IDX_W     (IDX_W)
	) u_table (
		.clk      (clk),
		.wr_en    (tbl_we),
		.wr_addr  (tbl_waddr),
		.wr_dur   (tbl_wdur),
		.wr_frame (tbl_wframe),
		.rd_addr  (tbl_raddr),
		.rd_dur   (tbl_rdur),
		.rd_frame (tbl_rframe)
	);

	afs_rem_unit #(
		.TOT_W (TOT_W)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rem_ctrl),
		.total  (total_q),
		.dur    (tbl_rdur),
		.ge     (rem_ge)
	);

endmodule

// ===== src/afs_checker.sv =====
// Port-level checker for the animation frame selector, bound to the top level.
// Depends on afs_pkg and on the port names of animation_frame_selector.
module afs_checker import afs_pkg::*; #(
	parameter int MAX_FRAMES = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input in_word_t              in_word,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_word_t             out_word,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A result offered but stalled stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed or dropped");

	// Every accepted query keeps the block busy for at least the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_word.mode == MODE_QUERY |=> in_stall)
		else $error("block ready right after accepting a query");

	// A new result is only produced by a busy block.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

	// A frame reported as valid lies within the frame limit.
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.frame_valid |-> 32'(out_word.frame_number) < MAX_FRAMES)
		else $error("valid frame number beyond the frame limit");

	// A configuration write (other than a zero start time) must not coincide with a stalled result word changing.
	logic cfg_seen;
	assign cfg_seen = cfg_we && (cfg_index != CFG_START_MS || cfg_data != '0);

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_seen |-> !(out_valid && out_stall && !$stable(out_word)))
		else $error("result word changed during a configuration write");

endmodule

bind animation_frame_selector afs_checker #(
	.MAX_FRAMES (MAX_FRAMES)
) u_afs_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for animation_frame_selector: step-table writes and
// time queries with random idling on both channels, checked against a predictor.
// Depends on afs_pkg and the animation_frame_selector RTL.
module tb import afs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default sizes; the predictor uses the same ones.
	localparam int MAX_STEPS = 64;
	localparam int MAX_FRAMES = 64;

	// Register index 3 is not decoded by the block; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// The watchdog limit lies above the longest query and the long receiver hold-off,
	// so a quiet stretch that reaches it can only mean a hang.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 185;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	animation_frame_selector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Words waiting to be offered, and the frame selections still owed by the block.
	in_word_t pending_words[$];
	out_word_t expected_frames[$];

	// The driver counts words it has put on the bus, the monitor counts words the
	// block took. While the two differ, the word on the bus is still being offered.
	int unsigned offer_count = 0;
	int unsigned accept_count = 0;
	int unsigned mismatch_count = 0;

	// Idling rates in percent, set per phase by the stimulus.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// The stimulus bumps holdoff_req to ask for a long receiver stall; the
	// receiver notices the change and counts the stall down on its own.
	int unsigned holdoff_req = 0;
	int unsigned holdoff_seen = 0;
	int unsigned holdoff_left = 0;

	// Predictor state: the step table, the running total and the registers.
	bit [31:0] tbl_dur[MAX_STEPS];
	bit [FRAME_W-1:0] tbl_frame[MAX_STEPS];
	bit [63:0] tbl_total = 0;
	logic [TIME_W-1:0] cfg_start_ms = '0;
	logic [CNT_W-1:0] cfg_frames = '0;
	logic [CNT_W-1:0] cfg_steps = '0;

	// Shadow of the table as the stimulus has planned it so far. Query times are
	// aimed at step boundaries with it; it runs ahead of the predictor's copy.
	bit [63:0] plan_dur[MAX_STEPS];
	bit [63:0] plan_total = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Applies one accepted word to the predictor. A write updates the table and
	// yields nothing; a query yields the frame selection the block must return.
	function automatic bit model_word(input in_word_t w, output out_word_t sel);
		logic [31:0] dur;
		logic [63:0] rem;
		logic [63:0] since;
		int unsigned nframes;
		int unsigned nsteps;
		int unsigned s;
		sel = '0;
		if (w.mode == MODE_WRITE) begin
			// A zero duration is kept as one millisecond.
			dur = (w.step_duration_ms == '0) ? 32'd1 : w.step_duration_ms;
			tbl_total = tbl_total - tbl_dur[w.step_index] + dur;
			tbl_dur[w.step_index] = dur;
			tbl_frame[w.step_index] = w.step_frame;
			return 1'b0;
		end
		nframes = (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : cfg_frames;
		nsteps = (cfg_steps > MAX_STEPS) ? MAX_STEPS : cfg_steps;
		if (nframes == 0 || nsteps == 0) begin
			return 1'b1;
		end
		// Before the start time, or with nothing loaded, the animation sits at step 0.
		rem = 0;
		if (w.now_ms >= cfg_start_ms && tbl_total != 0) begin
			since = {16'd0, w.now_ms} - {16'd0, cfg_start_ms};
			rem = since % tbl_total;
		end
		s = 0;
		while (s + 1 < nsteps && rem >= tbl_dur[s]) begin
			rem = rem - tbl_dur[s];
			s++;
		end
		sel.frame_number = tbl_frame[s];
		sel.frame_valid = (tbl_frame[s] < nframes);
		return 1'b1;
	endfunction

	// Half of the durations are short so walks span many steps quickly, with zero, the
	// largest value and full-width random values making up the rest.
	function automatic logic [31:0] pick_duration();
		int unsigned roll;
		roll = $urandom_range(15);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return '1;
		end else if (roll < 10) begin
			return $urandom_range(20, 1);
		end
		return $urandom;
	endfunction

	// Most query times land on a step boundary, one before it, or inside a step,
	// some periods after the start; the rest fall before the start or anywhere.
	function automatic logic [TIME_W-1:0] pick_query_time();
		int unsigned nsteps;
		int unsigned j;
		int unsigned i;
		int unsigned roll;
		logic [63:0] lead;
		logic [63:0] span;
		logic [63:0] t;
		nsteps = (cfg_steps > MAX_STEPS) ? MAX_STEPS : cfg_steps;
		if (nsteps == 0) begin
			nsteps = 1;
		end
		roll = $urandom_range(99);
		if (roll < 10 && cfg_start_ms != 0) begin
			t = rand64() % cfg_start_ms;
			return t[TIME_W-1:0];
		end
		if (roll < 22) begin
			t = rand64();
			return t[TIME_W-1:0];
		end
		j = $urandom_range(nsteps - 1);
		lead = 0;
		for (i = 0; i < j; i++) begin
			lead = lead + plan_dur[i];
		end
		span = plan_dur[j];
		case ($urandom_range(2))
			0: t = lead;
			1: t = lead + span - 1;
			default: t = lead + (rand64() % span);
		endcase
		t = t + cfg_start_ms + plan_total * $urandom_range(3);
		return t[TIME_W-1:0];
	endfunction

	// Count register data: the count in the low bits, random junk above it.
	function automatic logic [CFG_DATA_W-1:0] count_data(input int unsigned n);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(rand64());
		d[CNT_W-1:0] = CNT_W'(n);
		return d;
	endfunction

	function automatic void push_step_write(input int unsigned idx, input logic [31:0] dur,
			input logic [FRAME_W-1:0] fr);
		in_word_t w;
		logic [63:0] kept;
		w = '0;
		w.mode = MODE_WRITE;
		w.step_index = SIDX_W'(idx);
		w.step_duration_ms = dur;
		w.step_frame = fr;
		w.now_ms = TIME_W'(rand64());
		pending_words = {pending_words, w};
		kept = (dur == '0) ? 64'd1 : {32'd0, dur};
		plan_total = plan_total - plan_dur[idx] + kept;
		plan_dur[idx] = kept;
	endfunction

	// Queries carry random junk in the write fields, which the block must ignore.
	function automatic void push_query(input logic [TIME_W-1:0] now);
		in_word_t w;
		w.mode = MODE_QUERY;
		w.step_index = SIDX_W'($urandom);
		w.step_duration_ms = $urandom;
		w.step_frame = FRAME_W'($urandom);
		w.now_ms = now;
		pending_words = {pending_words, w};
	endfunction

	// The predictor's register copy is updated with the write, which is safe
	// because registers only change while no word is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_START_MS: cfg_start_ms = data[TIME_W-1:0];
			CFG_FRAME_COUNT: cfg_frames = data[CNT_W-1:0];
			CFG_STEP_COUNT: cfg_steps = data[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every word has been taken and every result has come back, then
	// lets tail cycles pass so a trailing table write can finish inside the block.
	task automatic wait_idle(input int unsigned tail);
		while (pending_words.size() != 0 || offer_count != accept_count
				|| expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (tail) @(posedge clk);
	endtask

	// Driver: words change at the falling edge. A word on the bus stays there
	// until it is taken; otherwise the next word goes out unless the sender idles.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && offer_count != accept_count)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_word <= pending_words.pop_front();
				in_valid <= 1'b1;
				offer_count <= offer_count + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when the stimulus asks for one.
	always @(negedge clk) begin
		if (holdoff_seen != holdoff_req) begin
			holdoff_seen <= holdoff_req;
			holdoff_left <= HOLDOFF_CYCLES;
			out_stall <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: results are checked before the word taken at the same edge is
	// predicted, since a result can never belong to a word accepted that cycle.
	always @(posedge clk) begin : check_results
		out_word_t want;
		out_word_t owed;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: result with none expected: got valid %0b frame %0d",
						$time, out_word.frame_valid, out_word.frame_number);
					mismatch_count++;
				end else begin
					want = expected_frames.pop_front();
					if (out_word.frame_valid !== want.frame_valid) begin
						$display("%0t: frame_valid mismatch: expected %0b, got %0b",
							$time, want.frame_valid, out_word.frame_valid);
						mismatch_count++;
					end
					if (out_word.frame_number !== want.frame_number) begin
						$display("%0t: frame_number mismatch: expected %0d, got %0d",
							$time, want.frame_number, out_word.frame_number);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (model_word(in_word, owed)) begin
					expected_frames = {expected_frames, owed};
				end
				accept_count <= accept_count + 1;
			end
		end
	end

	// Watchdog: too long without any word moving on either channel ends the run.
	always @(posedge clk) begin : watchdog
		int unsigned quiet_cycles;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0] start;
		int unsigned frames;
		int unsigned steps;
		int unsigned phase;
		int unsigned n;
		int unsigned i;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block clears its table after reset and takes register writes meanwhile.
		write_reg(CFG_START_MS, '0);
		write_reg(CFG_FRAME_COUNT, count_data(0));
		write_reg(CFG_STEP_COUNT, count_data(0));
		write_reg(CFG_UNUSED, CFG_DATA_W'(rand64()));

		// Directed part. With no frames and no steps a query selects nothing,
		// whatever the time.
		push_query('0);
		push_query('1);

		// Load four steps: a zero duration that must become 1 ms, the largest
		// duration, and a step that is then rewritten so the total must drop
		// the old duration.
		push_step_write(0, 32'd0, 6'd0);
		push_step_write(1, '1, 6'd63);
		push_step_write(2, 32'd5, 6'd2);
		push_step_write(3, 32'd10, 6'd7);
		push_step_write(2, 32'd3, 6'd5);
		wait_idle(20);

		// Eight frames, so the frame 63 of step 1 is out of range.
		write_reg(CFG_START_MS, 48'd100);
		write_reg(CFG_FRAME_COUNT, count_data(8));
		write_reg(CFG_STEP_COUNT, count_data(4));
		push_query(48'd0);
		push_query(48'd100);
		push_query(48'd101);
		push_query(48'd101 + 48'hFFFF_FFFF);
		push_query(48'd104 + 48'hFFFF_FFFF);
		push_query(TIME_W'(48'd99 + plan_total));
		push_query(TIME_W'(48'd100 + plan_total));
		push_query('1);
		wait_idle(20);

		// A frame count above the maximum acts as the maximum; one step in use
		// pins every query to step 0.
		write_reg(CFG_FRAME_COUNT, count_data(127));
		write_reg(CFG_STEP_COUNT, count_data(1));
		push_query(48'd12345);
		push_query(48'd101);
		wait_idle(20);

		// Steps loaded but no frames: nothing is selected.
		write_reg(CFG_FRAME_COUNT, count_data(0));
		write_reg(CFG_STEP_COUNT, count_data(4));
		push_query(48'd101);
		wait_idle(20);

		// Random phases. Each uses its own register setting and idling pattern;
		// the first loads the whole table so any step count is safe afterwards.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					start = '0;
					frames = 64;
					steps = 64;
				end
				1: begin
					start = '1;
					frames = 127;
					steps = 127;
				end
				2: begin
					start = TIME_W'(rand64());
					frames = 1;
					steps = 1;
				end
				3: begin
					start = TIME_W'(rand64() >> $urandom_range(47));
					frames = $urandom_range(127);
					steps = $urandom_range(127, 1);
				end
				4: begin
					start = TIME_W'(rand64());
					frames = 0;
					steps = 64;
				end
				5: begin
					start = TIME_W'($urandom_range(1000));
					frames = 32;
					steps = 127;
				end
				6: begin
					start = '0;
					frames = $urandom_range(127, 1);
					steps = 0;
				end
				default: begin
					start = TIME_W'(rand64() >> 20);
					frames = 64;
					steps = $urandom_range(64, 1);
				end
			endcase
			write_reg(CFG_START_MS, start);
			write_reg(CFG_FRAME_COUNT, count_data(frames));
			write_reg(CFG_STEP_COUNT, count_data(steps));
			if (phase == 3) begin
				write_reg(CFG_UNUSED, CFG_DATA_W'(rand64()));
			end

			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 18;
					recv_stall_pct = 18;
				end
			endcase

			if (phase == 0) begin
				for (i = 0; i < MAX_STEPS; i++) begin
					push_step_write(i, pick_duration(), FRAME_W'($urandom));
				end
			end

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Halfway through, the sender pauses until the block has answered
				// everything; in even phases the receiver then holds off for a long
				// stretch while words keep coming, so the block backs up its input.
				if (n == PHASE_ITEMS / 2) begin
					wait_idle(0);
					if (phase % 2 == 0) begin
						holdoff_req++;
					end
				end
				if ($urandom_range(3) == 0) begin
					push_step_write($urandom_range(MAX_STEPS - 1), pick_duration(),
						FRAME_W'($urandom));
				end else begin
					push_query(pick_query_time());
				end
			end
			wait_idle(20);
		end

		// Everything has been answered; leave room for any stray result to show up.
		wait_idle(200);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== animation_frame_selector.f =====
src/afs_pkg.sv
src/afs_rem_unit.sv
src/afs_step_table.sv
src/animation_frame_selector.sv
src/afs_checker.sv
sim/tb.sv
